@@ design/mcf_pkg.sv @@
// shared types and constants for the min-cost flow solver
// no dependencies; imported by the solver core, the relax unit and the testbench
package mcf_pkg;

   localparam int DistW = 32;
   localparam int CostW = 16;
   localparam int CapW  = 16;
   localparam int FlowW = 24;
   localparam int TotW  = 48;
   localparam int PortNodeW = 6;

   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_SOLVE = 1'b1;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_INFEASIBLE = 2'd1;
   localparam logic [1:0] STATUS_FULL       = 2'd2;
   localparam logic [1:0] STATUS_BAD_NODE   = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_BF_INIT, S_PASS_START, S_ARC_RD, S_ARC_GET, S_NODE_A, S_NODE_B,
      S_RELAX_F, S_RELAX_B, S_PASS_END, S_WALK_CHK, S_WALK_PRED, S_WALK_ARC,
      S_MUL, S_ACC, S_FIN
   } mcf_state_type;

   typedef struct packed {
      logic                    take;
      logic signed [DistW-1:0] cand_dist;
   } mcf_relax_type;

endpackage

@@ design/min_cost_flow_solver_core.sv @@
// min-cost flow solver by successive shortest paths over a loaded arc table
// depends on mcf_pkg, mcf_ram and mcf_relax_unit
// add item: result in the cycle after acceptance, one item per cycle while results drain
// solve item: per path, an init step, up to n relaxation passes over the arc table,
// then two walks of the path and a multiply-accumulate; then the result; ready low until it leaves
// reset clears the arc count, node count goes to 64; table contents need no clearing
module min_cost_flow_solver_core #(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // edge_from, edge_to, edge_capacity, edge_cost, source_node, sink_node, flow_amount
   input  logic [79:0] req_tdata,
   // req_type
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // total_cost
   output logic [47:0] rsp_tdata,
   // status
   output logic [1:0]  rsp_tuser,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);
   import mcf_pkg::*;

   localparam int NW  = $clog2(MAX_NODES);
   localparam int NCW = $clog2(MAX_NODES + 1);
   localparam int EW  = $clog2(MAX_EDGES);
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int TW  = EW + 1;
   localparam int AWD = 2 * NW + CostW + 2 * CapW;
   localparam int NWD = DistW + TW;
   localparam int OffCost = 2 * NW;
   localparam int OffFwd  = OffCost + CostW;
   localparam int OffBwd  = OffFwd + CapW;

   logic [PortNodeW-1:0] f_from, f_to, f_src, f_dst;
   logic [CapW-1:0]      f_cap;
   logic [CostW-1:0]     f_cost;
   logic [FlowW-1:0]     f_flow;
   assign f_from = req_tdata[5:0];
   assign f_to   = req_tdata[11:6];
   assign f_cap  = req_tdata[27:12];
   assign f_cost = req_tdata[43:28];
   assign f_src  = req_tdata[49:44];
   assign f_dst  = req_tdata[55:50];
   assign f_flow = req_tdata[79:56];

   mcf_state_type state_ff, state_in;
   logic [6:0]     node_count_ff;
   logic [ECW-1:0] arcs_ff, arcs_in;
   logic [NW-1:0]  src_ff, src_in, dst_ff, dst_in, a_ff, a_in, b_ff, b_in, v_ff, v_in;
   logic [FlowW-1:0] left_ff, left_in, push_ff, push_in;
   logic [TotW-1:0]  total_ff, total_in, prod_ff, prod_in;
   logic signed [DistW-1:0] dd_ff, dd_in, da_ff, da_in, db_ff, db_in;
   logic [MAX_NODES-1:0] seen_ff, seen_in;
   logic changed_ff, changed_in, aug_ff, aug_in;
   logic [NCW-1:0] pass_ff, pass_in, steps_ff, steps_in, live_n;
   logic [ECW-1:0] idx_ff, idx_in, idx_nxt;
   logic [CostW-1:0] cost_ff, cost_in;
   logic [CapW-1:0]  fwd_ff, fwd_in, bwd_ff, bwd_in;
   logic [TW-1:0]    tag_ff, tag_in;
   logic [1:0]       status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_user_ff, rsp_user_in;
   logic [TotW-1:0] rsp_data_ff, rsp_data_in;

   logic arc_we;
   logic [EW-1:0] arc_wa, arc_ra;
   logic [AWD-1:0] arc_wd, arc_q;
   logic node_we;
   logic [NW-1:0] node_wa, node_ra;
   logic [NWD-1:0] node_wd, node_q;

   logic rx_from_seen, rx_to_seen, rx_nz;
   logic signed [DistW-1:0] rx_from, rx_to;
   logic signed [CostW:0] rx_w;
   mcf_relax_type rx;
   logic signed [56:0] prod_full;

   logic [NW-1:0] q_tail, q_head, next_v;
   logic [CostW-1:0] q_cost;
   logic [CapW-1:0] q_fwd, q_bwd, q_cap;
   logic [TW-1:0] q_tag;

   assign q_tail = arc_q[NW-1:0];
   assign q_head = arc_q[2*NW-1:NW];
   assign q_cost = arc_q[OffCost +: CostW];
   assign q_fwd  = arc_q[OffFwd +: CapW];
   assign q_bwd  = arc_q[OffBwd +: CapW];
   assign q_cap  = tag_ff[0] ? q_bwd : q_fwd;
   assign next_v = tag_ff[0] ? q_head : q_tail;
   assign q_tag  = node_q[NWD-1:DistW];
   assign idx_nxt = idx_ff + 1'b1;
   assign prod_full = $signed({1'b0, push_ff}) * dd_ff;

   always_comb begin
      if (node_count_ff == 7'd0) begin
         live_n = NCW'(1);
      end else if (int'(node_count_ff) > MAX_NODES) begin
         live_n = NCW'(MAX_NODES);
      end else begin
         live_n = NCW'(node_count_ff);
      end
   end

   mcf_ram #(.WIDTH(AWD), .DEPTH(MAX_EDGES)) u_arc_ram (
      .clock(clock), .wr_en(arc_we), .wr_addr(arc_wa), .wr_data(arc_wd),
      .rd_addr(arc_ra), .rd_data(arc_q)
   );

   mcf_ram #(.WIDTH(NWD), .DEPTH(MAX_NODES)) u_node_ram (
      .clock(clock), .wr_en(node_we), .wr_addr(node_wa), .wr_data(node_wd),
      .rd_addr(node_ra), .rd_data(node_q)
   );

   mcf_relax_unit u_relax (
      .from_seen(rx_from_seen), .to_seen(rx_to_seen), .residual_nz(rx_nz),
      .from_dist(rx_from), .weight(rx_w), .to_dist(rx_to), .result(rx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= 7'd64;
         arcs_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         arcs_ff      <= arcs_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
      end
      src_ff <= src_in;  dst_ff <= dst_in;  a_ff <= a_in;  b_ff <= b_in;  v_ff <= v_in;
      left_ff <= left_in;  push_ff <= push_in;  total_ff <= total_in;  prod_ff <= prod_in;
      dd_ff <= dd_in;  da_ff <= da_in;  db_ff <= db_in;  seen_ff <= seen_in;
      changed_ff <= changed_in;  aug_ff <= aug_in;  pass_ff <= pass_in;
      steps_ff <= steps_in;  idx_ff <= idx_in;  cost_ff <= cost_in;
      fwd_ff <= fwd_in;  bwd_ff <= bwd_in;  tag_ff <= tag_in;  status_ff <= status_in;
      rsp_user_ff <= rsp_user_in;  rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in = state_ff;  arcs_in = arcs_ff;
      src_in = src_ff;  dst_in = dst_ff;  a_in = a_ff;  b_in = b_ff;  v_in = v_ff;
      left_in = left_ff;  push_in = push_ff;  total_in = total_ff;  prod_in = prod_ff;
      dd_in = dd_ff;  da_in = da_ff;  db_in = db_ff;  seen_in = seen_ff;
      changed_in = changed_ff;  aug_in = aug_ff;  pass_in = pass_ff;
      steps_in = steps_ff;  idx_in = idx_ff;  cost_in = cost_ff;
      fwd_in = fwd_ff;  bwd_in = bwd_ff;  tag_in = tag_ff;  status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in = rsp_user_ff;  rsp_data_in = rsp_data_ff;

      arc_we = 1'b0;  arc_wa = arcs_ff[EW-1:0];  arc_wd = '0;  arc_ra = idx_ff[EW-1:0];
      node_we = 1'b0;  node_wa = src_ff;  node_wd = '0;  node_ra = v_ff;

      rx_from_seen = seen_ff[a_ff];  rx_to_seen = seen_ff[b_ff];  rx_nz = (fwd_ff != '0);
      rx_from = da_ff;  rx_to = db_ff;  rx_w = $signed({1'b0, cost_ff});
      req_tready = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (req_tvalid && req_tready) begin
               rsp_data_in = '0;
               rsp_user_in = STATUS_OK;
               if (req_tuser[0] == REQ_ADD) begin
                  rsp_valid_in = 1'b1;
                  if (int'(f_from) >= int'(live_n) || int'(f_to) >= int'(live_n)) begin
                     rsp_user_in = STATUS_BAD_NODE;
                  end else if (int'(arcs_ff) >= MAX_EDGES) begin
                     rsp_user_in = STATUS_FULL;
                  end else begin
                     arc_we  = 1'b1;
                     arc_wd  = {CapW'(0), f_cap, f_cost, NW'(f_to), NW'(f_from)};
                     arcs_in = arcs_ff + 1'b1;
                  end
               end else if (int'(f_src) >= int'(live_n) || int'(f_dst) >= int'(live_n)) begin
                  rsp_valid_in = 1'b1;
                  rsp_user_in  = STATUS_BAD_NODE;
               end else if (f_flow == '0) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  src_in   = NW'(f_src);
                  dst_in   = NW'(f_dst);
                  left_in  = f_flow;
                  total_in = '0;
                  state_in = S_BF_INIT;
               end
            end
         end
         S_BF_INIT: begin
            seen_in = '0;
            seen_in[src_ff] = 1'b1;
            node_we = 1'b1;
            node_wa = src_ff;
            node_wd = '0;
            pass_in = '0;
            state_in = S_PASS_START;
         end
         S_PASS_START: begin
            changed_in = 1'b0;
            idx_in = '0;
            state_in = (arcs_ff == '0) ? S_PASS_END : S_ARC_RD;
         end
         S_ARC_RD: begin
            arc_ra = idx_ff[EW-1:0];
            state_in = S_ARC_GET;
         end
         S_ARC_GET: begin
            a_in = q_tail;  b_in = q_head;  cost_in = q_cost;
            fwd_in = q_fwd;  bwd_in = q_bwd;
            node_ra = q_tail;
            if (int'(q_tail) >= int'(live_n) || int'(q_head) >= int'(live_n)
                || (q_fwd == '0 && q_bwd == '0)) begin
               idx_in = idx_nxt;
               state_in = (idx_nxt == arcs_ff) ? S_PASS_END : S_ARC_RD;
            end else begin
               state_in = S_NODE_A;
            end
         end
         S_NODE_A: begin
            da_in = $signed(node_q[DistW-1:0]);
            node_ra = b_ff;
            state_in = S_NODE_B;
         end
         S_NODE_B: begin
            db_in = $signed(node_q[DistW-1:0]);
            state_in = S_RELAX_F;
         end
         S_RELAX_F: begin
            if (rx.take) begin
               node_we = 1'b1;
               node_wa = b_ff;
               node_wd = {idx_ff[EW-1:0], 1'b0, rx.cand_dist};
               seen_in[b_ff] = 1'b1;
               db_in = rx.cand_dist;
               if (a_ff == b_ff) begin
                  da_in = rx.cand_dist;
               end
               changed_in = 1'b1;
            end
            state_in = S_RELAX_B;
         end
         S_RELAX_B: begin
            rx_from_seen = seen_ff[b_ff];
            rx_to_seen = seen_ff[a_ff];
            rx_nz = (bwd_ff != '0);
            rx_from = db_ff;
            rx_to = da_ff;
            rx_w = -$signed({1'b0, cost_ff});
            if (rx.take) begin
               node_we = 1'b1;
               node_wa = a_ff;
               node_wd = {idx_ff[EW-1:0], 1'b1, rx.cand_dist};
               seen_in[a_ff] = 1'b1;
               changed_in = 1'b1;
            end
            idx_in = idx_nxt;
            state_in = (idx_nxt == arcs_ff) ? S_PASS_END : S_ARC_RD;
         end
         S_PASS_END: begin
            if (!changed_ff) begin
               if (seen_ff[dst_ff]) begin
                  v_in = dst_ff;  steps_in = '0;  aug_in = 1'b0;
                  push_in = left_ff;  dd_in = '0;
                  state_in = S_WALK_CHK;
               end else begin
                  status_in = STATUS_INFEASIBLE;
                  state_in = S_FIN;
               end
            end else if (pass_ff + 1'b1 == live_n) begin
               status_in = STATUS_INFEASIBLE;
               state_in = S_FIN;
            end else begin
               pass_in = pass_ff + 1'b1;
               state_in = S_PASS_START;
            end
         end
         S_WALK_CHK: begin
            node_ra = v_ff;
            if (v_ff == src_ff) begin
               if (aug_ff) begin
                  state_in = S_MUL;
               end else begin
                  aug_in = 1'b1;
                  v_in = dst_ff;
               end
            end else if (!aug_ff && steps_ff >= live_n) begin
               status_in = STATUS_INFEASIBLE;
               state_in = S_FIN;
            end else begin
               state_in = S_WALK_PRED;
            end
         end
         S_WALK_PRED: begin
            if (!aug_ff && steps_ff == '0) begin
               dd_in = $signed(node_q[DistW-1:0]);
            end
            tag_in = q_tag;
            arc_ra = q_tag[TW-1:1];
            state_in = S_WALK_ARC;
         end
         S_WALK_ARC: begin
            v_in = next_v;
            state_in = S_WALK_CHK;
            if (!aug_ff) begin
               if (FlowW'(q_cap) < push_ff) begin
                  push_in = FlowW'(q_cap);
               end
               steps_in = steps_ff + 1'b1;
               if (int'(next_v) >= int'(live_n)) begin
                  status_in = STATUS_INFEASIBLE;
                  state_in = S_FIN;
               end
            end else begin
               arc_we = 1'b1;
               arc_wa = tag_ff[TW-1:1];
               if (tag_ff[0]) begin
                  arc_wd = {q_bwd - CapW'(push_ff), q_fwd + CapW'(push_ff), q_cost,
                            q_head, q_tail};
               end else begin
                  arc_wd = {q_bwd + CapW'(push_ff), q_fwd - CapW'(push_ff), q_cost,
                            q_head, q_tail};
               end
            end
         end
         S_MUL: begin
            prod_in = prod_full[TotW-1:0];
            state_in = S_ACC;
         end
         S_ACC: begin
            total_in = total_ff + prod_ff;
            left_in = left_ff - push_ff;
            if (left_ff == push_ff) begin
               status_in = STATUS_OK;
               state_in = S_FIN;
            end else begin
               state_in = S_BF_INIT;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in = status_ff;
               rsp_data_in = (status_ff == STATUS_OK) ? total_ff : '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_arcs_bound: assert property (@(posedge clock) disable iff (reset)
      int'(arcs_ff) <= MAX_EDGES) else $error("arc count beyond table");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN && rsp_valid_ff && !rsp_tready |=> state_ff == S_FIN)
      else $error("result dropped while output stalled");
   a_walk_src_seen: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK_CHK |-> seen_ff[src_ff]) else $error("source lost its mark");
endmodule

@@ design/mcf_ram.sv @@
// generic single-port-write ram with one registered read port
// no dependencies; used for the arc table and the node table
module mcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/mcf_relax_unit.sv @@
// shared add and compare unit for one edge relaxation
// depends on mcf_pkg
module mcf_relax_unit (
   input  logic                             from_seen,
   input  logic                             to_seen,
   input  logic                             residual_nz,
   input  logic signed [mcf_pkg::DistW-1:0] from_dist,
   input  logic signed [mcf_pkg::CostW:0]   weight,
   input  logic signed [mcf_pkg::DistW-1:0] to_dist,
   output mcf_pkg::mcf_relax_type           result
);
   import mcf_pkg::*;

   logic signed [DistW-1:0] cand;

   assign cand = from_dist + DistW'(weight);

   always_comb begin
      result.cand_dist = cand;
      result.take = residual_nz && from_seen && (!to_seen || (cand < to_dist));
   end
endmodule

@@ dv/testbench.sv @@
// testbench for min_cost_flow_solver_core: directed table, then random edge loads and solves
// checked against an in-bench successive-shortest-path predictor; depends on mcf_pkg
module testbench;
   import mcf_pkg::*;

   localparam int NODES = 64;
   localparam int EDGES = 256;

   typedef struct {
      logic             kind;
      logic [5:0]       efrom, eto;
      logic [15:0]      ecap, ecost;
      logic [5:0]       src, snk;
      logic [23:0]      amount;
   } flow_req_type;

   typedef struct {
      logic [1:0]  status;
      logic [47:0] cost;
   } flow_rsp_type;

   typedef struct {
      flow_req_type item;
      bit           typed;
      flow_rsp_type want;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic [6:0]  csr_wr_data = '0;

   // flow solver shadow state
   int unsigned arc_from [EDGES];
   int unsigned arc_to [EDGES];
   int unsigned arc_price [EDGES];
   int unsigned fwd_left [EDGES];
   int unsigned bwd_left [EDGES];
   int unsigned arcs_held;
   logic [6:0]  node_setting;
   longint      dist_to [NODES];
   bit          reached [NODES];
   int unsigned came_by [NODES];

   flow_rsp_type  pending_rsp[$];
   int            error_count = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   table_row_type steps[$];

   min_cost_flow_solver_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned live_nodes();
      if (node_setting == 0) return 1;
      if (node_setting > NODES) return NODES;
      return 32'(node_setting);
   endfunction

   function automatic bit relax_arc(int unsigned a, int unsigned b, longint w,
                                    int unsigned tag);
      longint nd;
      if (!reached[a]) return 0;
      nd = dist_to[a] + w;
      if (reached[b] && nd >= dist_to[b]) return 0;
      reached[b] = 1;
      dist_to[b] = nd;
      came_by[b] = tag;
      return 1;
   endfunction

   // bellman-ford on true costs; 1 when the sink is reached with no negative cycle
   function automatic bit cheapest_paths(int unsigned n, int unsigned s, int unsigned t);
      bit changed;
      int unsigned a, b;
      changed = 1;
      for (int v = 0; v < n; v++) reached[v] = 0;
      reached[s] = 1;
      dist_to[s] = 0;
      for (int p = 0; p < n; p++) begin
         changed = 0;
         for (int i = 0; i < arcs_held; i++) begin
            a = arc_from[i];
            b = arc_to[i];
            if (a >= n || b >= n) continue;
            if (fwd_left[i] > 0 && relax_arc(a, b, longint'(arc_price[i]), 2 * i))
               changed = 1;
            if (bwd_left[i] > 0 && relax_arc(b, a, -longint'(arc_price[i]), 2 * i + 1))
               changed = 1;
         end
         if (!changed) break;
      end
      if (changed) return 0;
      return reached[t];
   endfunction

   function automatic bit push_flow(int unsigned s, int unsigned t, int unsigned amount,
                                    output longint unsigned cost);
      int unsigned n, left, push, v, hops, p, e, cap;
      longint unsigned total;
      n = live_nodes();
      total = 0;
      left = amount;
      cost = 0;
      while (left > 0) begin
         push = left;
         if (!cheapest_paths(n, s, t)) return 0;
         v = t;
         hops = 0;
         while (v != s) begin
            if (hops >= n) return 0;
            p = came_by[v];
            e = (p >> 1) % EDGES;
            cap = p[0] ? bwd_left[e] : fwd_left[e];
            if (cap < push) push = cap;
            v = p[0] ? arc_to[e] : arc_from[e];
            if (v >= n) return 0;
            hops++;
         end
         v = t;
         while (v != s) begin
            p = came_by[v];
            e = (p >> 1) % EDGES;
            if (p[0]) begin
               bwd_left[e] -= push;
               fwd_left[e] += push;
               v = arc_to[e];
            end else begin
               fwd_left[e] -= push;
               bwd_left[e] += push;
               v = arc_from[e];
            end
         end
         total += longint'(push) * longint'(dist_to[t]);
         left -= push;
      end
      cost = total;
      return 1;
   endfunction

   function automatic flow_rsp_type predict_rsp(flow_req_type it);
      flow_rsp_type r;
      longint unsigned c;
      int unsigned n;
      n = live_nodes();
      r.status = STATUS_OK;
      r.cost = '0;
      if (it.kind == REQ_ADD) begin
         if (it.efrom >= n || it.eto >= n) r.status = STATUS_BAD_NODE;
         else if (arcs_held >= EDGES) r.status = STATUS_FULL;
         else begin
            arc_from[arcs_held] = 32'(it.efrom);
            arc_to[arcs_held] = 32'(it.eto);
            fwd_left[arcs_held] = 32'(it.ecap);
            arc_price[arcs_held] = 32'(it.ecost);
            bwd_left[arcs_held] = 0;
            arcs_held++;
         end
      end else begin
         if (it.src >= n || it.snk >= n) r.status = STATUS_BAD_NODE;
         else if (!push_flow(32'(it.src), 32'(it.snk), 32'(it.amount), c))
            r.status = STATUS_INFEASIBLE;
         else r.cost = c[47:0];
      end
      return r;
   endfunction

   function automatic logic [5:0] pick_node();
      if ($urandom_range(99) < 88) return 6'($urandom_range(live_nodes() - 1));
      return 6'($urandom_range(63));
   endfunction

   function automatic logic [15:0] pick_word(int span);
      int r;
      r = $urandom_range(99);
      if (r < 10) return 16'hFFFF;
      if (r < 20) return 16'h0000;
      if (r < 40) return 16'($urandom_range(16'hFFFF));
      return 16'($urandom_range(span));
   endfunction

   function automatic flow_req_type random_req();
      flow_req_type it;
      int r;
      it.kind = ($urandom_range(99) < 4) ? REQ_SOLVE : REQ_ADD;
      it.efrom = pick_node();
      it.eto = pick_node();
      it.ecap = pick_word(30);
      it.ecost = pick_word(20);
      it.src = pick_node();
      it.snk = pick_node();
      r = $urandom_range(99);
      if (r < 10) it.amount = '0;
      else if (r < 14) it.amount = 24'hFFFFFF;
      else if (r < 20) it.amount = 24'($urandom_range(24'hFFFFFF));
      else it.amount = 24'($urandom_range(40, 1));
      return it;
   endfunction

   function automatic table_row_type row(logic kind, int f, int t, int cap, int cst, int s,
                                         int k, int amt, bit typed, logic [1:0] st,
                                         longint c);
      table_row_type x;
      x.item.kind = kind;
      x.item.efrom = 6'(f);
      x.item.eto = 6'(t);
      x.item.ecap = 16'(cap);
      x.item.ecost = 16'(cst);
      x.item.src = 6'(s);
      x.item.snk = 6'(k);
      x.item.amount = 24'(amt);
      x.typed = typed;
      x.want.status = st;
      x.want.cost = 48'(c);
      return x;
   endfunction

   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_req(flow_req_type it, bit typed, flow_rsp_type want);
      flow_rsp_type got;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.kind;
      req_tdata <= {it.amount, it.snk, it.src, it.ecost, it.ecap, it.eto, it.efrom};
      do @(posedge clock); while (!req_tready);
      got = predict_rsp(it);
      pending_rsp.push_back(typed ? want : got);
   endtask

   task automatic write_nodes(logic [6:0] value);
      req_tvalid <= 1'b0;
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      node_setting = value;
   endtask

   always @(posedge clock) begin
      flow_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected item: status %0d cost %0d", rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata !== want.cost) begin
                  $error("total_cost: expected %0d, got %0d", want.cost, rsp_tdata);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      #2_000_000_000;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      logic [6:0] settings [6] = '{7'd8, 7'd0, 7'd100, 7'd3, 7'd16, 7'd64};
      flow_rsp_type none;
      none = '{STATUS_OK, 48'd0};
      arcs_held = 0;
      node_setting = 7'd64;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, zero flow, equal endpoints, negative cycle, unreachable sink
      steps.push_back(row(REQ_ADD, 0, 63, 65535, 65535, 0, 0, 0, 1, STATUS_OK, 0));
      steps.push_back(row(REQ_ADD, 63, 0, 0, 0, 63, 63, 24'hFFFFFF, 1, STATUS_OK, 0));
      steps.push_back(row(REQ_ADD, 1, 2, 10, 3, 0, 0, 0, 0, STATUS_OK, 0));
      steps.push_back(row(REQ_SOLVE, 0, 0, 0, 0, 0, 63, 0, 1, STATUS_OK, 0));
      steps.push_back(row(REQ_SOLVE, 63, 63, 65535, 65535, 5, 5, 24'hFFFFFF, 1,
                          STATUS_OK, 0));
      steps.push_back(row(REQ_SOLVE, 0, 0, 0, 0, 0, 63, 1, 1, STATUS_OK, 65535));
      steps.push_back(row(REQ_SOLVE, 0, 0, 0, 0, 1, 2, 4, 1, STATUS_OK, 12));
      steps.push_back(row(REQ_SOLVE, 0, 0, 0, 0, 3, 4, 1, 1, STATUS_INFEASIBLE, 0));
      steps.push_back(row(REQ_SOLVE, 0, 0, 0, 0, 1, 2, 7, 0, STATUS_OK, 0));
      steps.push_back(row(REQ_ADD, 0, 63, 5, 0, 0, 0, 0, 1, STATUS_OK, 0));
      steps.push_back(row(REQ_SOLVE, 0, 0, 0, 0, 0, 63, 1, 1, STATUS_INFEASIBLE, 0));
      steps.push_back(row(REQ_ADD, 5, 6, 40, 2, 0, 0, 0, 0, STATUS_OK, 0));
      steps.push_back(row(REQ_ADD, 6, 7, 25, 4, 0, 0, 0, 0, STATUS_OK, 0));
      steps.push_back(row(REQ_SOLVE, 0, 0, 0, 0, 5, 7, 30, 0, STATUS_OK, 0));

      send_idle_pct = 14;
      recv_idle_pct = 64;
      write_nodes(7'd64);
      foreach (steps[i]) send_req(steps[i].item, steps[i].typed, steps[i].want);

      for (int ph = 0; ph < 6; ph++) begin
         send_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 64 : 0;
         recv_idle_pct = (ph < 2) ? 64 : (ph < 4) ? 14 : 0;
         write_nodes(settings[ph]);
         for (int k = 0; k < 275; k++) begin
            if (ph == 0 && k == 137) begin
               req_tvalid <= 1'b0;
               wait_drained();
            end
            send_req(random_req(), 0, none);
         end
      end
      req_tvalid <= 1'b0;
      wait_drained();

      if (error_count == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end
endmodule

@@ filelist.f @@
design/mcf_pkg.sv
design/mcf_ram.sv
design/mcf_relax_unit.sv
design/min_cost_flow_solver_core.sv
dv/testbench.sv
